// ===== rtl/tdl_pkg.sv =====
// Shared types, constants and thermistor tables of the divider linearizer.
`default_nettype none
package tdl_pkg;

  localparam int TablePoints = 15;
  localparam int SegW        = 4;
  localparam int Segs        = TablePoints - 1;

  localparam logic [21:0] ResMax = 22'h3FFFFF;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_OPEN  = 3'd1,
    ST_SHORT = 3'd2,
    ST_COLD  = 3'd3,
    ST_HOT   = 3'd4
  } tdl_status_e;

  localparam logic [1:0] RegPullup = 2'd0;
  localparam logic [1:0] RegSupply = 2'd1;
  localparam logic [1:0] RegMargin = 2'd2;

  // Table resistances scaled to 1/160 ohm (tenths of an ohm times 16).
  localparam logic [15:0] Ohm16 [0:TablePoints-1] = '{
    16'd57600, 16'd54704, 16'd41280, 16'd35104, 16'd32000, 16'd29728, 16'd26320,
    16'd22496, 16'd22256, 16'd19728, 16'd18848, 16'd16352, 16'd16144, 16'd14064,
    16'd13808
  };

  // Table temperatures in tenths of a degree.
  localparam logic [11:0] TblTemp [0:TablePoints-1] = '{
    12'd1300, 12'd1320, 12'd1490, 12'd1580, 12'd1597, 12'd1610, 12'd1710, 12'd1795,
    12'd1800, 12'd1870, 12'd1900, 12'd1970, 12'd2000, 12'd2090, 12'd2100
  };

  // Temperature step of each segment times 16.
  localparam logic [11:0] Dt16 [0:Segs-1] = '{
    12'd320, 12'd2720, 12'd1440, 12'd272, 12'd208, 12'd1600, 12'd1360,
    12'd80, 12'd1120, 12'd480, 12'd1120, 12'd480, 12'd1440, 12'd160
  };

  function automatic logic [28:0] base_f(input int i);
    int span;
    span = int'(Ohm16[i]) - int'(Ohm16[i+1]);
    return 29'(int'(TblTemp[i]) * 16 * span);
  endfunction

  function automatic logic [17:0] div10_f(input int i);
    return 18'((int'(Ohm16[i]) - int'(Ohm16[i+1])) * 10);
  endfunction

  localparam logic [28:0] Base [0:Segs-1] = '{
    base_f(0), base_f(1), base_f(2), base_f(3), base_f(4), base_f(5), base_f(6),
    base_f(7), base_f(8), base_f(9), base_f(10), base_f(11), base_f(12), base_f(13)
  };

  localparam logic [17:0] Div10 [0:Segs-1] = '{
    div10_f(0), div10_f(1), div10_f(2), div10_f(3), div10_f(4), div10_f(5),
    div10_f(6), div10_f(7), div10_f(8), div10_f(9), div10_f(10), div10_f(11),
    div10_f(12), div10_f(13)
  };

  typedef struct packed {
    tdl_status_e status;
    logic [30:0] num;
    logic [14:0] den;
  } tdl_item_t;

endpackage
`default_nettype wire

// ===== rtl/thermistor_divider_linearizer.sv =====
// Top level of the thermistor divider linearizer.
//
// Usage: drive a signed converter sample on adc_code_i and raise start. The
// request is taken at a rising edge where start is high and busy is low.
// Each request gives exactly one result: temp_q4_o, resistance_q4_o and
// status_o are valid for the single cycle in which done_o is high, and they
// come out in request order. The receiver cannot hold results off, and
// nothing here ever needs it to.
// Throughput is one request per clock cycle while busy is low. A result
// passes through the front register, the queue, the 22-step resistance
// divider, the classification and numerator registers, the 12-step
// interpolation divider and the output register; both dividers make one
// quotient bit per pipeline stage.
// The user must write configuration through cfg_we_i, cfg_idx_i and
// cfg_data_i only while no request is in flight; the block does not enforce
// it. Index 0: pull-up value, 1: supply code, 2: open margin, others ignored.
// Reset clears the pipeline, empties the queue and loads the register
// defaults; busy is low right after reset.
`default_nettype none
module thermistor_divider_linearizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] adc_code_i,
  output logic             done_o,
  output logic [11:0]      temp_q4_o,
  output logic [21:0]      resistance_q4_o,
  output logic [2:0]       status_o
);
  import tdl_pkg::*;

  tdl_item_t front_item, queue_item;
  logic      push, full, pop;

  // Front end: checks each sample and forms the divider operands.
  tdl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .busy       (busy),
    .adc_code_i (adc_code_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (front_item)
  );

  // The queue lets the front end and the back end run decoupled.
  tdl_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .full_o (full),
    .pop_o  (pop),
    .item_o (queue_item)
  );

  // Back end: division, table placement and interpolation.
  tdl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_i           (pop),
    .item_i          (queue_item),
    .done_o          (done_o),
    .temp_q4_o       (temp_q4_o),
    .resistance_q4_o (resistance_q4_o),
    .status_o        (status_o)
  );

endmodule
`default_nettype wire

// ===== rtl/tdl_front.sv =====
// Front end: configuration registers, sample acceptance, open and short checks.
`default_nettype none
module tdl_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [15:0]       adc_code_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output tdl_pkg::tdl_item_t     item_o
);
  import tdl_pkg::*;

  logic [15:0] pullup_q;
  logic [14:0] supply_q;
  logic [9:0]  margin_q;
  logic        fv_q, fv_d;
  tdl_item_t   item_q, item_d;
  logic        accept;
  logic signed [16:0] thresh, code_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pullup_q <= 16'd5280;
      supply_q <= 15'd26400;
      margin_q <= 10'd80;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPullup: pullup_q <= cfg_data_i;
        RegSupply: supply_q <= cfg_data_i[14:0];
        RegMargin: margin_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign busy   = fv_q && full_i;
  assign accept = start && !busy;
  assign push_o = fv_q && !full_i;
  assign item_o = item_q;

  always_comb begin
    thresh = $signed({2'b00, supply_q}) - $signed({7'd0, margin_q});
    code_x = $signed({adc_code_i[15], adc_code_i});
    item_d.num = 31'(pullup_q * adc_code_i[14:0]);
    item_d.den = supply_q - adc_code_i[14:0];
    if (code_x >= thresh) begin
      item_d.status = ST_OPEN;
    end else if (code_x <= 17'sd0) begin
      item_d.status = ST_SHORT;
    end else begin
      item_d.status = ST_OK;
    end
    fv_d = accept ? 1'b1 : (push_o ? 1'b0 : fv_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tdl_fifo.sv =====
// Two-entry queue between the front end and the arithmetic back end.
`default_nettype none
module tdl_fifo (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire tdl_pkg::tdl_item_t item_i,
  output logic                   full_o,
  output logic                   pop_o,
  output tdl_pkg::tdl_item_t     item_o
);
  import tdl_pkg::*;

  tdl_item_t   mem_q [0:1];
  logic        wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0]  cnt_q, cnt_d;

  // The back end never stalls, so an entry leaves as soon as it is present.
  assign pop_o  = (cnt_q != 2'd0);
  assign full_o = (cnt_q == 2'd2);
  assign item_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_o ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, push_i} - {1'b0, pop_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (push_i && !pop_o) |=> pop_o)
    else $error("pushed entry not visible");

endmodule
`default_nettype wire

// ===== rtl/tdl_back.sv =====
// Back end: resistance divider, table lookup and interpolation pipeline.
`default_nettype none
module tdl_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              pop_i,
  input  wire tdl_pkg::tdl_item_t item_i,
  output logic                   done_o,
  output logic [11:0]            temp_q4_o,
  output logic [21:0]            resistance_q4_o,
  output logic [2:0]             status_o
);
  import tdl_pkg::*;

  // Resistance divider stages.
  logic        av_q   [0:22];
  tdl_status_e ast_q  [0:22];
  logic        asat_q [0:22];
  logic [30:0] anum_q [0:22];
  logic [14:0] aden_q [0:22];
  logic [14:0] arem_q [0:22];
  logic [21:0] aq_q   [0:22];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      av_q[0] <= 1'b0;
    end else begin
      av_q[0] <= pop_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ast_q[0]  <= item_i.status;
    asat_q[0] <= ({6'd0, item_i.num} >= {item_i.den, 22'd0});
    anum_q[0] <= item_i.num;
    aden_q[0] <= item_i.den;
    arem_q[0] <= {6'd0, item_i.num[30:22]};
    aq_q[0]   <= 22'd0;
  end

  for (genvar k = 0; k < 22; k++) begin : g_div1
    logic [15:0] rem2;
    logic        ge;
    assign rem2 = {arem_q[k], anum_q[k][21-k]};
    assign ge   = rem2 >= {1'b0, aden_q[k]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        av_q[k+1] <= 1'b0;
      end else begin
        av_q[k+1] <= av_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      ast_q[k+1]  <= ast_q[k];
      asat_q[k+1] <= asat_q[k];
      anum_q[k+1] <= anum_q[k];
      aden_q[k+1] <= aden_q[k];
      arem_q[k+1] <= ge ? 15'(rem2 - {1'b0, aden_q[k]}) : rem2[14:0];
      aq_q[k+1]   <= aq_q[k] | (22'(ge) << (21 - k));
    end
  end

  // Classification against the table ends.
  logic [21:0]      res;
  logic [25:0]      rx;
  logic [SegW-1:0]  seg;
  tdl_status_e      cst;

  always_comb begin
    if (ast_q[22] != ST_OK) begin
      res = 22'd0;
    end else if (asat_q[22]) begin
      res = ResMax;
    end else begin
      res = aq_q[22];
    end
    rx  = 26'(res * 4'd10);
    seg = '0;
    for (int i = Segs - 1; i >= 0; i--) begin
      if (rx >= {10'd0, Ohm16[i+1]}) begin
        seg = SegW'(i);
      end
    end
    if (ast_q[22] != ST_OK) begin
      cst = ast_q[22];
    end else if (rx > {10'd0, Ohm16[0]}) begin
      cst = ST_COLD;
    end else if (rx < {10'd0, Ohm16[TablePoints-1]}) begin
      cst = ST_HOT;
    end else begin
      cst = ST_OK;
    end
  end

  logic            cv_q;
  tdl_status_e     cst_q;
  logic [21:0]     cres_q;
  logic [15:0]     crx_q;
  logic [SegW-1:0] cseg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= 1'b0;
    end else begin
      cv_q <= av_q[22];
    end
  end

  always_ff @(posedge clk_i) begin
    cst_q  <= cst;
    cres_q <= res;
    crx_q  <= rx[15:0];
    cseg_q <= seg;
  end

  // Interpolation numerator, then division by ten times the segment span.
  logic [15:0] diff;
  assign diff = Ohm16[cseg_q] - crx_q;

  logic        bv_q   [0:12];
  tdl_status_e bst_q  [0:12];
  logic [21:0] bres_q [0:12];
  logic [28:0] bn_q   [0:12];
  logic [17:0] bd_q   [0:12];
  logic [17:0] brem_q [0:12];
  logic [11:0] bq_q   [0:12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q[0] <= 1'b0;
    end else begin
      bv_q[0] <= cv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    bst_q[0]  <= cst_q;
    bres_q[0] <= cres_q;
    bn_q[0]   <= Base[cseg_q] + 29'(diff * Dt16[cseg_q]);
    bd_q[0]   <= Div10[cseg_q];
    brem_q[0] <= '0;
    bq_q[0]   <= '0;
  end

  for (genvar k = 0; k < 12; k++) begin : g_div2
    logic [18:0] rem2;
    logic [17:0] rem_in;
    logic        ge;
    // The first step starts from the numerator bits above the quotient.
    assign rem_in = (k == 0) ? {1'b0, bn_q[k][28:12]} : brem_q[k];
    assign rem2   = {rem_in, bn_q[k][11-k]};
    assign ge     = rem2 >= {1'b0, bd_q[k]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bv_q[k+1] <= 1'b0;
      end else begin
        bv_q[k+1] <= bv_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      bst_q[k+1]  <= bst_q[k];
      bres_q[k+1] <= bres_q[k];
      bn_q[k+1]   <= bn_q[k];
      bd_q[k+1]   <= bd_q[k];
      brem_q[k+1] <= ge ? 18'(rem2 - {1'b0, bd_q[k]}) : rem2[17:0];
      bq_q[k+1]   <= bq_q[k] | (12'(ge) << (11 - k));
    end
  end

  logic        done_q;
  logic [11:0] temp_q;
  logic [21:0] res_q;
  tdl_status_e st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= bv_q[12];
    end
  end

  always_ff @(posedge clk_i) begin
    temp_q <= (bst_q[12] == ST_OK) ? bq_q[12] : 12'd0;
    res_q  <= bres_q[12];
    st_q   <= bst_q[12];
  end

  assign done_o          = done_q;
  assign temp_q4_o       = temp_q;
  assign resistance_q4_o = res_q;
  assign status_o        = st_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && status_o != ST_OK) |-> temp_q4_o == 12'd0)
    else $error("temperature set on a failed sample");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && (status_o == ST_OPEN || status_o == ST_SHORT))
                   |-> resistance_q4_o == 22'd0)
    else $error("resistance set on open or short");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (done_o && status_o == ST_COLD)
                   |-> (26'(resistance_q4_o * 4'd10) > {10'd0, Ohm16[0]}))
    else $error("too cold reported inside the table");

endmodule
`default_nettype wire
